[hw/rtl/rcm_pkg.sv]
`default_nettype none

package rcm_pkg;

   // Default bitmap address width.
   localparam int HASH_BITS_DEF = 16;

   localparam int SUM_W  = 16;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 16;

   localparam logic [SUM_W-1:0] WIN_LEN_RST = 16'd700;
   localparam logic [POS_W-1:0] POS_MAX     = 16'hffff;

   // Configuration port: byte address 4*i, so bit 2 selects the register.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_LSB  = 2;
   localparam logic REG_WIN_LEN = 1'b0;

   typedef enum logic [1:0] {
      KIND_PREFIX = 2'd0,
      KIND_ROLL   = 2'd1,
      KIND_MARK   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // Access request from the pipeline to the presence bitmap.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } map_ctl_type;

   // Result fields held in the output register; hit is formed from the
   // bitmap read data and the roll flag.
   typedef struct packed {
      logic [SUM_W-1:0] sum_low;
      logic [SUM_W-1:0] sum_high;
      logic [SUM_W-1:0] hash_index;
      logic             roll;
      logic [POS_W-1:0] position;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/rolling_checksum_match.sv]
// Rolling checksum with block-match lookup.
//
// Items arrive on the req_ channel (valid/ready); each accepted transfer
// yields exactly one result transfer on the rsp_ channel, in order. Prefix
// and roll items update the two 16-bit running sums; a roll item also looks
// up the presence bitmap at (low XOR high) and reports hit. Mark items set a
// bitmap entry and clear items zero the sums.
//
// An item taken from req_ sits in the input register; when the result
// register is free or being taken, the sum update and the bitmap access load
// the result register and the bitmap read register together, and rsp_valid
// rises. Throughput is one item per cycle while rsp_ready stays high; the
// bitmap is a single-port memory used at most once per item.
//
// After reset the bitmap is swept clear, one entry per cycle, through all
// 2**HASH_BITS entries (65536 by default). req_ready stays low while it
// runs; the window length may be written over the APB port meanwhile. When
// the receiver holds rsp_ready low, the result register holds its item and
// the input register can still take one more item before req_ready drops.
`default_nettype none

module rolling_checksum_match
   import rcm_pkg::*;
#(
   parameter int HASH_BITS = HASH_BITS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_kind,
   input  wire logic [BYTE_W-1:0]     req_new_byte,
   input  wire logic [BYTE_W-1:0]     req_old_byte,
   input  wire logic [SUM_W-1:0]      req_mark_index,
   input  wire logic                  req_run_end,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [SUM_W-1:0]           rsp_sum_low_out,
   output logic [SUM_W-1:0]           rsp_sum_high_out,
   output logic [SUM_W-1:0]           rsp_hash_index,
   output logic                       rsp_hit,
   output logic [POS_W-1:0]           rsp_position,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [SUM_W-1:0]     win_len;
   logic                 clearing;
   map_ctl_type          map_ctl;
   logic [HASH_BITS-1:0] map_addr;
   logic                 map_rd_data;
   result_type           result;

   // The register port never stalls.
   assign pready = 1'b1;

   rcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .win_len (win_len)
   );

   rcm_pipe #(
      .HASH_BITS (HASH_BITS)
   ) u_pipe (
      .clock          (clock),
      .reset          (reset),
      .win_len        (win_len),
      .clearing       (clearing),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_new_byte   (req_new_byte),
      .req_old_byte   (req_old_byte),
      .req_mark_index (req_mark_index),
      .req_run_end    (req_run_end),
      .map_ctl        (map_ctl),
      .map_addr       (map_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .result         (result)
   );

   rcm_map #(
      .HASH_BITS (HASH_BITS)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .ctl      (map_ctl),
      .addr     (map_addr),
      .rd_data  (map_rd_data),
      .clearing (clearing)
   );

   // On a roll item the bitmap read register is loaded together with the
   // result register, so it holds its value for as long as the result waits.
   // Only a roll item reports a hit.
   assign rsp_sum_low_out  = result.sum_low;
   assign rsp_sum_high_out = result.sum_high;
   assign rsp_hash_index   = result.hash_index;
   assign rsp_hit          = result.roll && map_rd_data;
   assign rsp_position     = result.position;

endmodule

`default_nettype wire

[hw/rtl/rcm_csr.sv]
`default_nettype none

module rcm_csr
   import rcm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic      [SUM_W-1:0]      win_len
);

   logic [SUM_W-1:0] win_len_ff;
   logic             sel_win_len;
   logic             wr_en;

   assign sel_win_len = (paddr[CSR_IDX_LSB] == REG_WIN_LEN);
   assign wr_en       = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= WIN_LEN_RST;
      end else if (wr_en && sel_win_len) begin
         win_len_ff <= pwdata[SUM_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_win_len) begin
         prdata = {{(CSR_DATA_W-SUM_W){1'b0}}, win_len_ff};
      end
   end

   assign win_len = win_len_ff;

endmodule

`default_nettype wire

[hw/rtl/rcm_map.sv]
`default_nettype none

module rcm_map
   import rcm_pkg::*;
#(
   parameter int HASH_BITS = HASH_BITS_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire map_ctl_type          ctl,
   input  wire logic [HASH_BITS-1:0] addr,
   output logic                      rd_data,
   output logic                      clearing
);

   localparam int DEPTH = 1 << HASH_BITS;

   logic                 mem [DEPTH];
   logic                 rd_data_ff;
   logic                 clr_active_ff;
   logic [HASH_BITS-1:0] clr_addr_ff;

   // One entry is cleared per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= 1'b0;
      end else if (ctl.wr_en) begin
         mem[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_active_ff;

endmodule

`default_nettype wire

[hw/rtl/rcm_pipe.sv]
`default_nettype none

module rcm_pipe
   import rcm_pkg::*;
#(
   parameter int HASH_BITS = HASH_BITS_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [SUM_W-1:0]     win_len,
   input  wire logic                 clearing,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_kind,
   input  wire logic [BYTE_W-1:0]    req_new_byte,
   input  wire logic [BYTE_W-1:0]    req_old_byte,
   input  wire logic [SUM_W-1:0]     req_mark_index,
   input  wire logic                 req_run_end,
   output map_ctl_type               map_ctl,
   output logic [HASH_BITS-1:0]      map_addr,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output result_type                result
);

   localparam int PROD_W = SUM_W + BYTE_W;

   // Input register.
   logic                 s1_valid_ff;
   kind_type             s1_kind_ff;
   logic [BYTE_W-1:0]    s1_new_ff;
   logic [BYTE_W-1:0]    s1_old_ff;
   logic [HASH_BITS-1:0] s1_mark_ff;
   logic                 s1_end_ff;
   logic [SUM_W-1:0]     s1_prod_ff;

   // Running state.
   logic [SUM_W-1:0] sum_low_ff;
   logic [SUM_W-1:0] sum_high_ff;
   logic [POS_W-1:0] run_pos_ff;
   logic [SUM_W-1:0] sum_low_in;
   logic [SUM_W-1:0] sum_high_in;
   logic [POS_W-1:0] run_pos_in;

   // Result register.
   logic       s2_valid_ff;
   result_type res_ff;
   result_type res_in;

   logic              s2_adv;
   logic              s1_move;
   logic              s1_open;
   logic              req_take;
   logic [PROD_W-1:0] prod_full;
   logic [SUM_W-1:0]  hash_x;
   logic              is_byte;

   assign s2_adv    = !s2_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && s2_adv;
   assign s1_open   = !s1_valid_ff || s2_adv;
   assign req_ready = !clearing && s1_open;
   assign req_take  = req_valid && req_ready;

   // The window length product is formed ahead of the sum update.
   assign prod_full = PROD_W'(win_len) * PROD_W'(req_old_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_open) begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff <= kind_type'(req_kind);
         s1_new_ff  <= req_new_byte;
         s1_old_ff  <= req_old_byte;
         s1_mark_ff <= req_mark_index[HASH_BITS-1:0];
         s1_end_ff  <= req_run_end;
         s1_prod_ff <= prod_full[SUM_W-1:0];
      end
   end

   always_comb begin
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      is_byte     = 1'b0;
      case (s1_kind_ff)
         KIND_PREFIX: begin
            sum_low_in  = sum_low_ff + SUM_W'(s1_new_ff);
            sum_high_in = sum_high_ff + sum_low_in;
            is_byte     = 1'b1;
         end
         KIND_ROLL: begin
            sum_low_in  = sum_low_ff + SUM_W'(s1_new_ff) - SUM_W'(s1_old_ff);
            sum_high_in = sum_high_ff + sum_low_in - s1_prod_ff;
            is_byte     = 1'b1;
         end
         KIND_CLEAR: begin
            sum_low_in  = '0;
            sum_high_in = '0;
         end
         default: begin
            sum_low_in  = sum_low_ff;
            sum_high_in = sum_high_ff;
         end
      endcase
   end

   always_comb begin
      run_pos_in = run_pos_ff;
      if (is_byte) begin
         if (s1_end_ff) begin
            run_pos_in = '0;
         end else if (run_pos_ff != POS_MAX) begin
            run_pos_in = run_pos_ff + 1'b1;
         end
      end
   end

   assign hash_x   = sum_low_in ^ sum_high_in;
   assign map_addr = (s1_kind_ff == KIND_MARK) ? s1_mark_ff : hash_x[HASH_BITS-1:0];

   always_comb begin
      map_ctl.wr_en = s1_move && (s1_kind_ff == KIND_MARK);
      map_ctl.rd_en = s1_move && (s1_kind_ff == KIND_ROLL);
   end

   always_comb begin
      res_in.sum_low    = sum_low_in;
      res_in.sum_high   = sum_high_in;
      res_in.hash_index = SUM_W'(map_addr);
      res_in.roll       = (s1_kind_ff == KIND_ROLL);
      res_in.position   = run_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_low_ff  <= '0;
         sum_high_ff <= '0;
         run_pos_ff  <= '0;
      end else if (s1_move) begin
         sum_low_ff  <= sum_low_in;
         sum_high_ff <= sum_high_in;
         run_pos_ff  <= run_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign result    = res_ff;

endmodule

`default_nettype wire

[hw/rtl/rcm_checker.sv]
`default_nettype none

module rcm_checker
   import rcm_pkg::*;
#(
   parameter int HASH_BITS = HASH_BITS_DEF
)
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [SUM_W-1:0]  rsp_sum_low_out,
   input wire logic [SUM_W-1:0]  rsp_sum_high_out,
   input wire logic [SUM_W-1:0]  rsp_hash_index,
   input wire logic              rsp_hit,
   input wire logic [POS_W-1:0]  rsp_position
);

   localparam logic [SUM_W-1:0] IDX_MASK = SUM_W'((32'd1 << HASH_BITS) - 32'd1);

   // The bitmap sweep keeps the input closed right after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input open right after reset");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // A hit only comes from a roll, whose index is the XOR of the sums.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |->
         rsp_hash_index == ((rsp_sum_low_out ^ rsp_sum_high_out) & IDX_MASK))
      else $error("hit with an index that is not the sum XOR");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hash_index & ~IDX_MASK) == '0)
      else $error("index beyond the bitmap width");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
         && $stable(rsp_hit) && $stable(rsp_sum_high_out))
      else $error("stalled result changed");

endmodule

bind rolling_checksum_match rcm_checker #(
   .HASH_BITS (HASH_BITS)
) u_rcm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sum_low_out  (rsp_sum_low_out),
   .rsp_sum_high_out (rsp_sum_high_out),
   .rsp_hash_index   (rsp_hash_index),
   .rsp_hit          (rsp_hit),
   .rsp_position     (rsp_position)
);

`default_nettype wire

[dv/tb_rolling_checksum_match.sv]
`timescale 1ns / 100ps

module tb_rolling_checksum_match;
   import rcm_pkg::*;

   // The block is built with its default bitmap width, so the testbench
   // keeps a full-size copy of the presence bitmap.
   localparam int HASH_BITS = HASH_BITS_DEF;
   localparam int MAP_DEPTH = 1 << HASH_BITS;
   localparam logic [SUM_W-1:0] HASH_MASK = SUM_W'(MAP_DEPTH - 1);

   // The bitmap sweep after reset keeps req_ready low while it clears all
   // MAP_DEPTH entries, so the limit on cycles without any transfer is several sweeps long.
   localparam int WATCHDOG_LIMIT = 4 * MAP_DEPTH + 20000;
   localparam int LONG_HOLD      = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 8;

   // Register addresses: one register, byte address 4*i.
   localparam int SPARE_REG = 1;
   localparam logic [CSR_ADDR_W-1:0] WIN_LEN_ADDR =
      CSR_ADDR_W'(REG_WIN_LEN) << CSR_IDX_LSB;
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(SPARE_REG) << CSR_IDX_LSB;

   typedef struct packed {
      logic [SUM_W-1:0] sum_low;
      logic [SUM_W-1:0] sum_high;
      logic [SUM_W-1:0] hash_index;
      logic             hit;
      logic [POS_W-1:0] position;
   } checksum_result_type;

   // Every input starts at a known value.
   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic [1:0]            req_kind       = 2'(KIND_PREFIX);
   logic [BYTE_W-1:0]     req_new_byte   = '0;
   logic [BYTE_W-1:0]     req_old_byte   = '0;
   logic [SUM_W-1:0]      req_mark_index = '0;
   logic                  req_run_end    = 1'b0;
   logic                  rsp_ready      = 1'b1;
   logic                  psel           = 1'b0;
   logic                  penable        = 1'b0;
   logic                  pwrite         = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr          = '0;
   logic [CSR_DATA_W-1:0] pwdata         = '0;

   logic                  req_ready;
   logic                  rsp_valid;
   logic [SUM_W-1:0]      rsp_sum_low_out;
   logic [SUM_W-1:0]      rsp_sum_high_out;
   logic [SUM_W-1:0]      rsp_hash_index;
   logic                  rsp_hit;
   logic [POS_W-1:0]      rsp_position;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rolling_checksum_match DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_new_byte     (req_new_byte),
      .req_old_byte     (req_old_byte),
      .req_mark_index   (req_mark_index),
      .req_run_end      (req_run_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sum_low_out  (rsp_sum_low_out),
      .rsp_sum_high_out (rsp_sum_high_out),
      .rsp_hash_index   (rsp_hash_index),
      .rsp_hit          (rsp_hit),
      .rsp_position     (rsp_position),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Predicted state of the block: the configuration, both running sums,
   // the run position and the presence bitmap. The bitmap starts cleared,
   // which matches the sweep the block performs after reset.
   logic [SUM_W-1:0] model_win_len = WIN_LEN_RST;
   logic [SUM_W-1:0] model_low     = '0;
   logic [SUM_W-1:0] model_high    = '0;
   logic [POS_W-1:0] model_pos     = '0;
   bit               presence [MAP_DEPTH];

   checksum_result_type expected_q [$];

   // Controls shared between the test tasks and the two traffic processes.
   bit send_idle = 1'b1;
   bit sink_idle = 1'b1;
   int hold_rsp  = 0;

   int kind_count [4];
   int hits_expected   = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int mismatches      = 0;
   int quiet_cycles    = 0;

   function automatic void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
   endfunction

   // Bitmap address that a roll with these bytes would look up from the
   // current sums. Used to mark an entry ahead of a roll so that it hits.
   function automatic logic [SUM_W-1:0] roll_index(logic [BYTE_W-1:0] nb, logic [BYTE_W-1:0] ob);
      logic [SUM_W-1:0] lo;
      logic [SUM_W-1:0] hi;
      lo = model_low + SUM_W'(nb) - SUM_W'(ob);
      hi = model_high + lo - model_win_len * SUM_W'(ob);
      return (lo ^ hi) & HASH_MASK;
   endfunction

   // Advances the predicted state by one item and returns the result that
   // the block must produce for it. All sum arithmetic wraps at 16 bits.
   function automatic checksum_result_type step_checksum(kind_type k, logic [BYTE_W-1:0] nb,
                                                         logic [BYTE_W-1:0] ob,
                                                         logic [SUM_W-1:0] mk, logic last);
      checksum_result_type r;
      logic is_byte;
      r.position = model_pos;
      r.hit      = 1'b0;
      is_byte    = 1'b0;
      case (k)
         KIND_PREFIX: begin
            model_low  = model_low + SUM_W'(nb);
            model_high = model_high + model_low;
            is_byte    = 1'b1;
         end
         KIND_ROLL: begin
            model_low  = model_low + SUM_W'(nb) - SUM_W'(ob);
            model_high = model_high + model_low - model_win_len * SUM_W'(ob);
            is_byte    = 1'b1;
         end
         KIND_CLEAR: begin
            model_low  = '0;
            model_high = '0;
         end
         default: ;
      endcase
      // A mark reports the entry it set; every other kind reports the
      // address formed from the sums, and only a roll reads the bitmap.
      if (k == KIND_MARK) begin
         presence[mk & HASH_MASK] = 1'b1;
         r.hash_index = mk & HASH_MASK;
      end else begin
         r.hash_index = (model_low ^ model_high) & HASH_MASK;
         if (k == KIND_ROLL) r.hit = presence[r.hash_index];
      end
      // Only byte items move the position; it saturates instead of wrapping.
      if (is_byte) begin
         if (last) model_pos = '0;
         else if (model_pos != POS_MAX) model_pos = model_pos + 1'b1;
      end
      r.sum_low  = model_low;
      r.sum_high = model_high;
      return r;
   endfunction

   // Offers one item and waits for its transfer. Valid is only lowered when
   // a gap precedes the item, so it is never lowered and raised in one step.
   // The prediction is made at the edge of the transfer, in transfer order.
   task automatic send_item(kind_type k, logic [BYTE_W-1:0] nb, logic [BYTE_W-1:0] ob,
                            logic [SUM_W-1:0] mk, logic last);
      int gap;
      checksum_result_type r;
      gap = 0;
      if (send_idle && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= k;
      req_new_byte   <= nb;
      req_old_byte   <= ob;
      req_mark_index <= mk;
      req_run_end    <= last;
      do @(posedge clock); while (!req_ready);
      r = step_checksum(k, nb, ob, mk, last);
      expected_q.push_back(r);
      kind_count[k]++;
      if (r.hit) hits_expected++;
   endtask

   task automatic send_noise();
      send_item(kind_type'($urandom_range(0, 3)), BYTE_W'($urandom), BYTE_W'($urandom),
                SUM_W'($urandom), 1'($urandom_range(0, 1)));
   endtask

   // Stops offering items and waits for every predicted result, then lets
   // the pipeline settle so that the block is idle for a register write.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB access: a setup phase, then an access phase that completes at
   // the edge where pready is seen high. An idle phase with psel low follows
   // so that psel is never dropped and raised in the same step.
   task automatic csr_cycle(logic wr, logic [CSR_ADDR_W-1:0] addr,
                            logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] unused;
      csr_cycle(1'b1, addr, data, unused);
      // Writes to any index other than the window length leave the block alone.
      if ((addr >> CSR_IDX_LSB) == CSR_ADDR_W'(REG_WIN_LEN))
         model_win_len = data[SUM_W-1:0];
      csr_writes++;
   endtask

   task automatic csr_check_win_len();
      logic [CSR_DATA_W-1:0] rd;
      csr_cycle(1'b0, WIN_LEN_ADDR, '0, rd);
      if (rd[SUM_W-1:0] !== model_win_len)
         flag_mismatch($sformatf("window length read exp %h got %h", model_win_len,
                                 rd[SUM_W-1:0]));
   endtask

   // The receiver idles in random bursts while sink_idle is set. A test can
   // ask for one long hold-off through hold_rsp; the count runs here.
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (hold_rsp > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_rsp) @(posedge clock);
            hold_rsp = 0;
            rsp_ready <= 1'b1;
         end else if (sink_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Each result transfer is compared field by field with the oldest
   // prediction. Outputs are read at the edge, before the block updates.
   always @(posedge clock) begin : result_check
      checksum_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            flag_mismatch($sformatf("result transfer with nothing expected, low %h high %h",
                                    rsp_sum_low_out, rsp_sum_high_out));
         end else begin
            exp_r = expected_q.pop_front();
            results_checked++;
            if (rsp_sum_low_out !== exp_r.sum_low)
               flag_mismatch($sformatf("sum_low exp %h got %h", exp_r.sum_low,
                                       rsp_sum_low_out));
            if (rsp_sum_high_out !== exp_r.sum_high)
               flag_mismatch($sformatf("sum_high exp %h got %h", exp_r.sum_high,
                                       rsp_sum_high_out));
            if (rsp_hash_index !== exp_r.hash_index)
               flag_mismatch($sformatf("hash_index exp %h got %h", exp_r.hash_index,
                                       rsp_hash_index));
            if (rsp_hit !== exp_r.hit)
               flag_mismatch($sformatf("hit exp %b got %b", exp_r.hit, rsp_hit));
            if (rsp_position !== exp_r.position)
               flag_mismatch($sformatf("position exp %h got %h", exp_r.position,
                                       rsp_position));
         end
      end
   end

   // Ends the run when neither channel has seen a transfer for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, expected_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Reset value of the window length, and a write to an unused index that
   // must not disturb it. This runs while the bitmap sweep is still going on.
   task automatic test_csr_defaults();
      csr_check_win_len();
      csr_write(SPARE_ADDR, $urandom);
      csr_check_win_len();
   endtask

   // Prefix items with the byte extremes; old_byte and mark_index carry
   // values that a prefix must ignore. The third item ends the run.
   task automatic test_prefix_extremes();
      send_item(KIND_PREFIX, 8'h00, 8'hff, 16'hffff, 1'b0);
      send_item(KIND_PREFIX, 8'hff, 8'h00, 16'h0000, 1'b0);
      send_item(KIND_PREFIX, 8'hff, 8'hff, 16'h5a5a, 1'b1);
      send_item(KIND_PREFIX, 8'h80, 8'h01, 16'h0001, 1'b0);
   endtask

   // Rolls at the reset window length: the largest leaving byte, a miss,
   // and a roll whose entry was marked first so that it hits. The sums on
   // a hit must stay as computed.
   task automatic test_roll_lookup();
      send_item(KIND_ROLL, 8'h00, 8'hff, 16'hffff, 1'b0);
      send_item(KIND_ROLL, 8'hff, 8'h00, 16'h0000, 1'b0);
      send_item(KIND_MARK, 8'h00, 8'h00, roll_index(8'h12, 8'h34), 1'b0);
      send_item(KIND_ROLL, 8'h12, 8'h34, 16'h0000, 1'b1);
      send_item(KIND_ROLL, 8'h01, 8'h01, 16'hffff, 1'b0);
   endtask

   // Marks at both ends of the bitmap, with run_end set where it must be
   // ignored. A clear zeroes the sums, so the next roll with equal bytes
   // looks up entry zero and hits, while a prefix at the same address
   // reports no hit.
   task automatic test_mark_clear();
      send_item(KIND_MARK, 8'hff, 8'hff, 16'h0000, 1'b1);
      send_item(KIND_MARK, 8'h00, 8'h00, 16'hffff, 1'b0);
      send_item(KIND_CLEAR, 8'hff, 8'hff, 16'hffff, 1'b1);
      send_item(KIND_ROLL, 8'h00, 8'h00, 16'h0000, 1'b0);
      send_item(KIND_CLEAR, 8'h00, 8'h00, 16'h0000, 1'b0);
      send_item(KIND_PREFIX, 8'h00, 8'h00, 16'h0000, 1'b0);
   endtask

   // Smallest and largest window lengths, the smallest written with junk in
   // the upper data bits, then back to the reset value.
   task automatic test_win_len_extremes();
      wait_results_drained();
      csr_write(WIN_LEN_ADDR, {16'hffff, 16'h0001});
      csr_check_win_len();
      send_item(KIND_PREFIX, 8'hff, 8'h00, 16'h0000, 1'b0);
      send_item(KIND_ROLL, 8'h10, 8'hff, 16'h0000, 1'b0);
      wait_results_drained();
      csr_write(WIN_LEN_ADDR, {16'h0000, 16'hffff});
      csr_write(SPARE_ADDR, '1);
      csr_check_win_len();
      send_item(KIND_ROLL, 8'h00, 8'hff, 16'h0000, 1'b0);
      send_item(KIND_ROLL, 8'hff, 8'hff, 16'h0000, 1'b0);
      wait_results_drained();
      csr_write(WIN_LEN_ADDR, CSR_DATA_W'(WIN_LEN_RST));
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering back to back, so the block fills and stalls its input. The
   // sender then pauses until every result has come.
   task automatic test_backpressure();
      send_idle = 1'b0;
      hold_rsp  = LONG_HOLD;
      repeat (40) send_noise();
      wait_results_drained();
      send_idle = 1'b1;
   endtask

   // Random phase at one window length. Most items form proper rolling
   // windows: a prefix fills the window, then each roll removes the byte
   // that entered span items earlier. A quarter of the rolls are preceded
   // by a mark of the entry they will look up. A run end is followed by a
   // clear so that the next window starts from zero sums. The rest is
   // noise: clears at random points and items with every field random.
   task automatic test_random_stream(int n_items, logic [SUM_W-1:0] bs, bit idle);
      logic [BYTE_W-1:0] window [$];
      logic [BYTE_W-1:0] nb;
      logic [BYTE_W-1:0] ob;
      logic              last;
      int                span;
      int                sent;
      wait_results_drained();
      csr_write(WIN_LEN_ADDR, {16'($urandom), bs});
      csr_check_win_len();
      send_idle = idle;
      sink_idle = idle;
      span = (bs <= 64) ? int'(bs) : $urandom_range(8, 64);
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               send_noise();
               sent++;
            end
            3: begin
               send_item(KIND_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom), SUM_W'($urandom),
                         1'($urandom_range(0, 1)));
               window.delete();
               sent++;
            end
            default: begin
               nb = BYTE_W'($urandom);
               if (window.size() < span) begin
                  window.push_back(nb);
                  last = ($urandom_range(0, 99) == 0);
                  send_item(KIND_PREFIX, nb, BYTE_W'($urandom), SUM_W'($urandom), last);
               end else begin
                  ob = window.pop_front();
                  window.push_back(nb);
                  if ($urandom_range(0, 3) == 0) begin
                     send_item(KIND_MARK, BYTE_W'($urandom), BYTE_W'($urandom),
                               roll_index(nb, ob), 1'($urandom_range(0, 1)));
                     sent++;
                  end
                  last = ($urandom_range(0, 49) == 0);
                  send_item(KIND_ROLL, nb, ob, SUM_W'($urandom), last);
               end
               sent++;
               if (last) begin
                  send_item(KIND_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom), SUM_W'($urandom),
                            1'b0);
                  window.delete();
                  sent++;
               end
            end
         endcase
      end
   endtask

   initial begin : run_tests
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_csr_defaults();
      test_prefix_extremes();
      test_roll_lookup();
      test_mark_clear();
      test_win_len_extremes();
      test_backpressure();

      // Random phases across several window lengths, the extremes among
      // them; one phase runs without idling, and so does the last one.
      test_random_stream(300, 16'd1, 1'b1);
      test_random_stream(300, 16'hffff, 1'b1);
      test_random_stream(300, 16'($urandom_range(2, 64)), 1'b0);
      test_random_stream(300, 16'($urandom_range(1, 65535)), 1'b1);
      test_random_stream(300, 16'($urandom_range(2, 32)), 1'b1);
      test_random_stream(500, WIN_LEN_RST, 1'b0);

      wait_results_drained();

      $display("Sent %0d prefix, %0d roll, %0d mark and %0d clear items; %0d rolls hit.",
               kind_count[KIND_PREFIX], kind_count[KIND_ROLL], kind_count[KIND_MARK],
               kind_count[KIND_CLEAR], hits_expected);
      $display("Checked %0d results over %0d register writes, with a long receiver hold-off.",
               results_checked, csr_writes);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
